/* hdl/smpf_pkg.sv */
package smpf_pkg;

  // Default queue depth in bytes
  localparam int FIFO_DEPTH_DEF = 128;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  // Input item commands
  typedef logic [IN_TUSER_W-1:0] cmd_code_t;
  localparam cmd_code_t CMD_MOUSE = 2'd0;
  localparam cmd_code_t CMD_TICK  = 2'd1;
  localparam cmd_code_t CMD_REGWR = 2'd2;

  // UART register constants
  localparam logic [2:0] REG_MCR        = 3'd4;
  localparam int         MCR_DETECT_BIT = 1;

  // Packet constants
  localparam logic [7:0] PKT_HDR_BASE = 8'h40;
  localparam logic [7:0] PKT_DY_SIGN  = 8'h0C;
  localparam logic [7:0] PKT_DX_SIGN  = 8'h03;
  localparam logic [7:0] PKT_LOW_MASK = 8'h3F;
  localparam logic [7:0] DETECT_BYTE  = 8'h4D;

  // Byte source for a push
  typedef logic [1:0] bsel_t;
  localparam bsel_t BSEL_HDR = 2'd0;
  localparam bsel_t BSEL_DX  = 2'd1;
  localparam bsel_t BSEL_DY  = 2'd2;
  localparam bsel_t BSEL_DET = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  clear;
    logic  push;
    logic  pop;
    logic  drop;
    logic  finish;
    bsel_t bsel;
  } smpf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_code_t item_cmd;
    logic      detect;
    logic      full;
    logic      empty;
    logic      idle;
    logic      sent;
    logic      out_free;
  } smpf_stat_t;

endpackage

/* hdl/smpf_dpath.sv */
module smpf_dpath #(
  parameter int FIFO_DEPTH = smpf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smpf_pkg::smpf_cmd_t                cmd,
  output smpf_pkg::smpf_stat_t               stat,
  input  logic [smpf_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [smpf_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [smpf_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import smpf_pkg::*;

  localparam int ADDR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Captured item
  cmd_code_t         cmd_r;
  logic signed [6:0] dx_r;
  logic signed [6:0] dy_r;
  logic [1:0]        btn_r;
  logic [2:0]        reg_r;
  logic [7:0]        mcr_r;
  logic              idle_r;

  // Queue state
  logic [7:0]        mem [FIFO_DEPTH];
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        rd_data_r;
  logic              sent_r;
  logic              dropped_r;

  // Output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [SUM_W-1:0]  wr_sum;
  logic [SUM_W-1:0]  wr_sum_wrap;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        push_byte;
  logic [7:0]        hdr_byte;
  logic              full;

  assign full = (count_r == CNT_W'(FIFO_DEPTH));

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_tuser;
      dx_r   <= in_tdata[6:0];
      dy_r   <= in_tdata[13:7];
      btn_r  <= in_tdata[15:14];
      reg_r  <= in_tdata[18:16];
      mcr_r  <= in_tdata[26:19];
      idle_r <= in_tdata[27];
    end
  end

  // Build the byte to push
  always_comb begin
    hdr_byte = PKT_HDR_BASE | {2'b00, btn_r, 4'b0000};
    if (dy_r[6]) hdr_byte = hdr_byte | PKT_DY_SIGN;
    if (dx_r[6]) hdr_byte = hdr_byte | PKT_DX_SIGN;
    case (cmd.bsel)
      BSEL_HDR: push_byte = hdr_byte;
      BSEL_DX:  push_byte = {1'b0, dx_r} & PKT_LOW_MASK;
      BSEL_DY:  push_byte = {1'b0, dy_r} & PKT_LOW_MASK;
      default:  push_byte = DETECT_BYTE;
    endcase
  end

  // Tail address: head plus count, wrapped once
  always_comb begin
    wr_sum      = SUM_W'(head_r) + SUM_W'(count_r);
    wr_sum_wrap = (wr_sum >= SUM_W'(FIFO_DEPTH)) ? (wr_sum - SUM_W'(FIFO_DEPTH)) : wr_sum;
    wr_addr     = wr_sum_wrap[ADDR_W-1:0];
  end

  // Byte memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= push_byte;
    end
    if (cmd.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

  // Advance head and count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
      head_nxt  = (head_r == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      sent_r    <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cmd.load) begin
        sent_r    <= 1'b0;
        dropped_r <= 1'b0;
      end else begin
        if (cmd.pop)  sent_r    <= 1'b1;
        if (cmd.drop) dropped_r <= 1'b1;
      end
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= {6'b000000, 8'(count_r), dropped_r,
                     (sent_r ? rd_data_r : 8'h00), sent_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller
  always_comb begin
    stat.item_cmd = cmd_r;
    stat.detect   = (reg_r == REG_MCR) && mcr_r[MCR_DETECT_BIT];
    stat.full     = full;
    stat.empty    = (count_r == '0);
    stat.idle     = idle_r;
    stat.sent     = sent_r;
    stat.out_free = !out_valid_r || out_tready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("fill count above depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !full)
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty queue");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result overwritten before transaction");

endmodule

/* hdl/smpf_ctrl.sv */
module smpf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  smpf_pkg::smpf_stat_t stat,
  output smpf_pkg::smpf_cmd_t  cmd
);
  import smpf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [1:0] MODE_PKT  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_DET  = 2'd2;

  localparam logic [1:0] IDX_LAST = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       last_byte;

  assign in_tready = (state_r == S_IDLE);
  assign last_byte = (mode_r != MODE_PKT) || (idx_r == IDX_LAST);

  // Sequence one item through decode, clear, push, pop and result steps
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    mode_nxt  = mode_r;
    if (mode_r == MODE_DET) begin
      cmd.bsel = BSEL_DET;
    end else begin
      case (idx_r)
        2'd0:    cmd.bsel = BSEL_HDR;
        2'd1:    cmd.bsel = BSEL_DX;
        default: cmd.bsel = BSEL_DY;
      endcase
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_nxt = '0;
        case (stat.item_cmd)
          CMD_MOUSE: begin
            mode_nxt  = MODE_PKT;
            state_nxt = S_PUSH;
          end
          CMD_TICK: begin
            mode_nxt  = MODE_TICK;
            state_nxt = stat.empty ? S_DONE : S_POP;
          end
          CMD_REGWR: begin
            mode_nxt  = MODE_DET;
            state_nxt = stat.detect ? S_CLEAR : S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (stat.full) begin
          cmd.drop  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.push = 1'b1;
          if (stat.idle && !stat.sent) begin
            state_nxt = S_POP;
          end else if (last_byte) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (last_byte) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PUSH;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      mode_r  <= MODE_PKT;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mode_r  <= mode_nxt;
    end
  end

  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.sent)
    else $error("second byte sent in one item");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DECODE))
    else $error("load did not start decode");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("packet byte index out of range");

endmodule

/* hdl/serial_mouse_packet_fifo_unit.sv */
// Serial mouse packet encoder with transmit byte queue.
//
// Input stream (in_*): one transaction per event. in_tuser selects the
// command: mouse event, transmitter ready tick or UART register write.
// Output stream (out_*): exactly one result per input transaction, giving
// the byte handed to the transmitter (if any), the drop flag for a packet
// that found the queue full, and the fill level after the event.
//
// A mouse event takes a decode step, one push step per byte (stopping with a
// drop when the queue is full), a send step after the first push when the
// transmitter is idle, and the result step; a ready tick takes decode, one
// read of the byte memory when the queue is not empty, and the result step.
// The single write port of the byte memory sets the pace of a packet;
// items are taken one at a time.
// A new transaction is taken once the previous one is in the output
// register, so the next item may overlap a stalled result.
//
// Reset clears the queue pointers and the output valid; the byte memory
// is not cleared. When the receiver stalls, the result holds in the
// output register and the controller waits before finishing the next item.
module serial_mouse_packet_fifo_unit #(
  parameter int FIFO_DEPTH = smpf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // dx[6:0], dy[13:7], buttons[15:14], reg_index[18:16],
  // modem_control[26:19], uart_idle[27], zero fill above
  input  logic [smpf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [smpf_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tx_valid[0], tx_byte[8:1], dropped[9], fill_level[17:10], zero fill above
  output logic [smpf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import smpf_pkg::*;

  smpf_cmd_t  cmd;
  smpf_stat_t stat;

  smpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smpf_dpath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* test/serial_mouse_packet_fifo_unit_test.sv */
`timescale 1ns / 100ps

module serial_mouse_packet_fifo_unit_test;
  import smpf_pkg::*;

  localparam int          QDEPTH       = FIFO_DEPTH_DEF;
  localparam int unsigned LIMIT_CYCLES = 400000;
  // Command code with no function in the block
  localparam cmd_code_t   CMD_NOP      = 2'd3;

  // One input transaction, split into its fields
  typedef struct packed {
    cmd_code_t  cmd;
    logic [6:0] dx;
    logic [6:0] dy;
    logic [1:0] buttons;
    logic [2:0] reg_idx;
    logic [7:0] mcr;
    logic       idle;
  } uart_evt_t;

  // One result transaction, split into its fields
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       dropped;
    logic [7:0] fill;
  } tx_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Byte queue as the transmitter sees it
  logic [7:0]  txq_mem [QDEPTH];
  int unsigned txq_head;
  int unsigned txq_count;

  tx_report_t  tx_reports_due [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned rx_hold_req;

  serial_mouse_packet_fifo_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("serial_mouse_packet_fifo_unit_test: done, errors");
      $finish;
    end
  end

  // Take the oldest queued byte
  function automatic logic [7:0] txq_pop();
    logic [7:0] b;
    b = txq_mem[txq_head];
    txq_head = (txq_head + 1) % QDEPTH;
    txq_count--;
    return b;
  endfunction

  // Queue one byte if there is room; the first push of a step may send
  function automatic bit txq_push(input logic [7:0] b, input logic idle,
                                  inout logic sent, inout logic [7:0] sent_byte);
    if (txq_count >= QDEPTH) return 1'b0;
    txq_mem[(txq_head + txq_count) % QDEPTH] = b;
    txq_count++;
    if (idle && !sent) begin
      sent_byte = txq_pop();
      sent = 1'b1;
    end
    return 1'b1;
  endfunction

  // Encode the event, update the queue and work out the report
  function automatic tx_report_t encode_and_queue(input uart_evt_t e);
    tx_report_t r;
    logic [7:0] pkt [3];
    logic       sent;
    logic       drop;
    logic [7:0] sb;
    sent = 1'b0;
    drop = 1'b0;
    sb   = 8'h00;
    case (e.cmd)
      CMD_MOUSE: begin
        pkt[0] = PKT_HDR_BASE | {2'b00, e.buttons, 4'b0000}
               | (e.dy[6] ? PKT_DY_SIGN : 8'h00) | (e.dx[6] ? PKT_DX_SIGN : 8'h00);
        pkt[1] = {1'b0, e.dx} & PKT_LOW_MASK;
        pkt[2] = {1'b0, e.dy} & PKT_LOW_MASK;
        for (int i = 0; i < 3 && !drop; i++)
          if (!txq_push(pkt[i], e.idle, sent, sb)) drop = 1'b1;
      end
      CMD_TICK: begin
        if (txq_count > 0) begin
          sb   = txq_pop();
          sent = 1'b1;
        end
      end
      CMD_REGWR: begin
        if (e.reg_idx == REG_MCR && e.mcr[MCR_DETECT_BIT]) begin
          txq_head  = 0;
          txq_count = 0;
          void'(txq_push(DETECT_BYTE, e.idle, sent, sb));
        end
      end
      default: ;
    endcase
    r.tx_valid = sent;
    r.tx_byte  = sent ? sb : 8'h00;
    r.dropped  = drop;
    r.fill     = 8'(txq_count);
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic uart_evt_t evt(input cmd_code_t cmd, input int dx, input int dy,
                                    input int buttons, input int reg_idx,
                                    input int mcr, input int idle);
    uart_evt_t e;
    e.cmd     = cmd;
    e.dx      = 7'(dx);
    e.dy      = 7'(dy);
    e.buttons = 2'(buttons);
    e.reg_idx = 3'(reg_idx);
    e.mcr     = 8'(mcr);
    e.idle    = 1'(idle);
    return e;
  endfunction

  function automatic uart_evt_t rand_evt(input cmd_code_t cmd);
    uart_evt_t e;
    e     = uart_evt_t'($urandom);
    e.cmd = cmd;
    return e;
  endfunction

  // Offer one transaction and record its expected report on acceptance
  task automatic send_evt(input uart_evt_t e, input int unsigned gap);
    in_tdata  <= {4'b0000, e.idle, e.mcr, e.reg_idx, e.buttons, e.dy, e.dx};
    in_tuser  <= e.cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tx_reports_due.push_back(encode_and_queue(e));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input until every report has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (tx_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: check each report and stall at random
  initial begin : rx_side
    tx_report_t  want;
    int unsigned stall_left;
    int unsigned calm_left;
    out_tready <= 1'b0;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
        if (tx_reports_due.size() == 0) begin
          $error("unexpected result transaction %h", out_tdata);
          mismatch_count++;
        end else begin
          want = tx_reports_due.pop_front();
          check_field("tx_valid", want.tx_valid, out_tdata[0]);
          check_field("tx_byte", want.tx_byte, out_tdata[8:1]);
          check_field("dropped", want.dropped, out_tdata[9]);
          check_field("fill_level", want.fill, out_tdata[17:10]);
        end
      end
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(30, 120);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Detect byte on a modem control write, ticks with non-empty and empty queue
  task automatic test_detect_byte();
    send_evt(evt(CMD_REGWR, 0, 0, 0, REG_MCR, 8'h02, 0), pick_gap());
    send_evt(evt(CMD_TICK, 0, 0, 0, 0, 0, 0), pick_gap());
    send_evt(evt(CMD_TICK, 0, 0, 0, 0, 0, 1), pick_gap());
    send_evt(evt(CMD_REGWR, 0, 0, 0, REG_MCR, 8'hFF, 1), pick_gap());
    send_evt(evt(CMD_TICK, 0, 0, 0, 0, 0, 0), pick_gap());
    wait_drain();
  endtask

  // Motion and button extremes, with and without an idle transmitter
  task automatic test_packet_fields();
    send_evt(evt(CMD_MOUSE, -64, 63, 3, 0, 0, 1), pick_gap());
    send_evt(evt(CMD_MOUSE, 63, -64, 0, 0, 0, 0), pick_gap());
    send_evt(evt(CMD_MOUSE, 0, 0, 1, 7, 8'hFF, 0), pick_gap());
    send_evt(evt(CMD_MOUSE, -1, -1, 2, 0, 0, 1), pick_gap());
    send_evt(evt(CMD_MOUSE, 1, -63, 3, 0, 0, 0), pick_gap());
    repeat (12) send_evt(evt(CMD_TICK, 0, 0, 0, 0, 0, 0), pick_gap());
    wait_drain();
  endtask

  // Writes that do nothing, unused command, detect over a busy queue
  task automatic test_ignored_writes();
    send_evt(evt(CMD_MOUSE, 5, -5, 1, 0, 0, 0), pick_gap());
    send_evt(evt(CMD_REGWR, 0, 0, 0, REG_MCR, 8'hFD, 1), pick_gap());
    send_evt(evt(CMD_REGWR, 0, 0, 0, 3, 8'hFF, 1), pick_gap());
    send_evt(evt(CMD_REGWR, 0, 0, 0, 7, 8'h02, 1), pick_gap());
    send_evt(evt(CMD_REGWR, 0, 0, 0, 0, 8'h02, 0), pick_gap());
    send_evt(rand_evt(CMD_NOP), pick_gap());
    send_evt(evt(CMD_REGWR, 0, 0, 0, REG_MCR, 8'h02, 0), pick_gap());
    send_evt(evt(CMD_TICK, 0, 0, 0, 0, 0, 1), pick_gap());
    wait_drain();
  endtask

  // Fill the queue to the top, drop whole and partial packets, drain past wrap
  task automatic test_fill_and_drop();
    uart_evt_t e;
    send_evt(evt(CMD_REGWR, 0, 0, 0, REG_MCR, 8'h02, 0), pick_gap());
    repeat (42) begin
      e      = rand_evt(CMD_MOUSE);
      e.idle = 1'b0;
      send_evt(e, pick_gap());
    end
    // one byte of room: the oldest byte goes out, the packet hits the top
    e = rand_evt(CMD_MOUSE); e.idle = 1'b1; send_evt(e, pick_gap());
    e = rand_evt(CMD_MOUSE); e.idle = 1'b0; send_evt(e, pick_gap());
    e = rand_evt(CMD_MOUSE); e.idle = 1'b1; send_evt(e, pick_gap());
    send_evt(rand_evt(CMD_TICK), pick_gap());
    e = rand_evt(CMD_MOUSE); e.idle = 1'b0; send_evt(e, pick_gap());
    send_evt(rand_evt(CMD_TICK), pick_gap());
    send_evt(rand_evt(CMD_TICK), pick_gap());
    e = rand_evt(CMD_MOUSE); e.idle = 1'b0; send_evt(e, pick_gap());
    repeat (135) send_evt(rand_evt(CMD_TICK), pick_gap());
    wait_drain();
  endtask

  // Long receiver stall while the sender keeps offering back to back
  task automatic test_backpressure();
    rx_hold_req = 300;
    repeat (12) send_evt(rand_evt($urandom_range(0, 3) == 0 ? CMD_TICK : CMD_MOUSE), 0);
    wait_drain();
  endtask

  // Episodes of fill-heavy or drain-heavy traffic with some noise
  task automatic test_random_traffic();
    uart_evt_t   e;
    int unsigned counted;
    int unsigned mouse_pct;
    int unsigned len;
    int unsigned r;
    bit          calm;
    counted = 0;
    while (counted < 330) begin
      calm      = ($urandom_range(0, 3) == 0);
      len       = $urandom_range(5, 40);
      r         = $urandom_range(0, 2);
      mouse_pct = (r == 0) ? 30 : (r == 1) ? 60 : 85;
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < mouse_pct) begin
          e      = rand_evt(CMD_MOUSE);
          e.idle = ($urandom_range(0, 3) == 0);
          counted++;
        end else if (r < 96) begin
          e = rand_evt(CMD_TICK);
          counted++;
        end else if (r < 98) begin
          e         = rand_evt(CMD_REGWR);
          e.reg_idx = REG_MCR;
          e.mcr[MCR_DETECT_BIT] = 1'b1;
          counted++;
        end else begin
          e = rand_evt($urandom_range(0, 1) ? CMD_REGWR : CMD_NOP);
        end
        send_evt(e, calm ? 0 : pick_gap());
      end
    end
    wait_drain();
  endtask

  initial begin
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= CMD_MOUSE;
    rst_n          <= 1'b0;
    txq_head       = 0;
    txq_count      = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    rx_hold_req    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_detect_byte();
    test_packet_fields();
    test_ignored_writes();
    test_fill_and_drop();
    test_backpressure();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && tx_reports_due.size() == 0) begin
      $display("serial_mouse_packet_fifo_unit_test: done, clean");
    end else begin
      $display("serial_mouse_packet_fifo_unit_test: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/smpf_pkg.sv
hdl/smpf_dpath.sv
hdl/smpf_ctrl.sv
hdl/serial_mouse_packet_fifo_unit.sv
test/serial_mouse_packet_fifo_unit_test.sv
